### design/gpev_pkg.sv
// Shared types, constants and helper functions for the gamepad event generator.
package gpev_pkg;

  localparam int unsigned BUTTON_COUNT = 16;
  localparam int unsigned AXIS_COUNT   = 4;
  localparam logic signed [15:0] DIR_THR     = 16'sd25000;
  localparam logic signed [15:0] DIR_THR_NEG = -DIR_THR;

  // event slot layout walked by the back end
  localparam int unsigned SLOT_COUNT = 34;
  localparam int unsigned SLOT_W     = 6;
  localparam logic [SLOT_W-1:0] SLOT_BTN  = 6'd2;
  localparam logic [SLOT_W-1:0] SLOT_TRIG = 6'd18;
  localparam logic [SLOT_W-1:0] SLOT_AXIS = 6'd22;

  localparam logic [4:0] SYM_TRIG     = 5'd16;
  localparam logic [4:0] SYM_AXIS     = 5'd18;
  localparam logic [4:0] SYM_TRIG_BTN = 5'd22;

  typedef enum logic [1:0] {
    CFG_DEAD_ZONE = 2'd0,
    CFG_GAIN      = 2'd1,
    CFG_TRIG_THR  = 2'd2,
    CFG_BTN_MASK  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EV_CONNECT    = 2'd0,
    EV_DISCONNECT = 2'd1,
    EV_DIGITAL    = 2'd2,
    EV_ANALOG     = 2'd3
  } ev_kind_t;

  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic        op;
    logic        connected;
    logic [15:0] buttons;
    logic [7:0]  trigger_left;
    logic [7:0]  trigger_right;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
  } in_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [4:0]  symbol_id;
    logic        pressed;
    logic signed [15:0] value;
    logic        forced;
    logic        last;
  } out_t;

  // one classified report as handed from front to back
  typedef struct packed {
    logic             op;
    logic             connected;
    logic [15:0]      buttons;
    logic [1:0][7:0]  trig;
    logic [3:0][15:0] axis;   // scaled, two's complement
  } job_t;

  typedef struct packed {
    logic hit;
    logic press;
  } cross_t;

  typedef struct packed {
    logic [1:0] axis;
    logic [1:0] sub;
  } axis_slot_t;

  // direction symbol for an axis and polarity
  function automatic logic [4:0] dir_sym(input logic [1:0] a, input logic pos);
    logic [4:0] s;
    case (a)
      2'd0:    s = pos ? 5'd27 : 5'd26;
      2'd1:    s = pos ? 5'd24 : 5'd25;
      2'd2:    s = pos ? 5'd31 : 5'd30;
      2'd3:    s = pos ? 5'd28 : 5'd29;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // threshold crossing at +T (pos) or -T
  function automatic cross_t crossing(input logic signed [15:0] pv,
                                      input logic signed [15:0] cur,
                                      input logic pos);
    cross_t c;
    c = '0;
    if (pos) begin
      if (pv >= DIR_THR && cur < DIR_THR) begin
        c.hit = 1'b1;
      end else if (pv <= DIR_THR && cur > DIR_THR) begin
        c.hit   = 1'b1;
        c.press = 1'b1;
      end
    end else begin
      if (pv <= DIR_THR_NEG && cur > DIR_THR_NEG) begin
        c.hit = 1'b1;
      end else if (pv >= DIR_THR_NEG && cur < DIR_THR_NEG) begin
        c.hit   = 1'b1;
        c.press = 1'b1;
      end
    end
    return c;
  endfunction

  // axis slots come in groups of three: value, then two crossings
  function automatic axis_slot_t axis_slot(input logic [3:0] r);
    axis_slot_t t;
    case (r)
      4'd0:    t = '{axis: 2'd0, sub: 2'd0};
      4'd1:    t = '{axis: 2'd0, sub: 2'd1};
      4'd2:    t = '{axis: 2'd0, sub: 2'd2};
      4'd3:    t = '{axis: 2'd1, sub: 2'd0};
      4'd4:    t = '{axis: 2'd1, sub: 2'd1};
      4'd5:    t = '{axis: 2'd1, sub: 2'd2};
      4'd6:    t = '{axis: 2'd2, sub: 2'd0};
      4'd7:    t = '{axis: 2'd2, sub: 2'd1};
      4'd8:    t = '{axis: 2'd2, sub: 2'd2};
      4'd9:    t = '{axis: 2'd3, sub: 2'd0};
      4'd10:   t = '{axis: 2'd3, sub: 2'd1};
      4'd11:   t = '{axis: 2'd3, sub: 2'd2};
      default: t = '{axis: 2'd0, sub: 2'd0};
    endcase
    return t;
  endfunction

endpackage

### design/gpev_front.sv
// Front end: accepts reports and rescales the stick axes out of the dead zone.
module gpev_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gpev_pkg::in_t     in_data,
  input  logic [14:0]       dead_zone,
  input  logic [23:0]       dead_zone_gain,
  output logic              push,
  output gpev_pkg::job_t    push_data,
  input  logic              full
);
  import gpev_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CALC = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t      state_r, state_nxt;
  job_t         job_r, job_nxt;
  logic [2:0]   idx_r, idx_nxt;
  logic [40:0]  prod_r, prod_nxt;
  logic         neg_r, neg_nxt;

  logic [15:0]  raw;
  logic [16:0]  mag;
  logic [16:0]  excess;
  logic [24:0]  scaled;
  logic [14:0]  sat;
  logic [15:0]  signed_val;

  assign in_ready  = (state_r == F_IDLE);
  assign push      = (state_r == F_PUSH) && !full;
  assign push_data = job_r;

  always_comb begin
    raw    = job_r.axis[idx_r[1:0]];
    mag    = raw[15] ? (17'd0 - {raw[15], raw}) : {1'b0, raw};
    excess = (mag > {2'b00, dead_zone}) ? (mag - {2'b00, dead_zone}) : 17'd0;
    scaled = prod_r[40:16];
    sat    = (|scaled[24:15]) ? 15'h7FFF : scaled[14:0];
    signed_val = neg_r ? (16'd0 - {1'b0, sat}) : {1'b0, sat};
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    idx_nxt   = idx_r;
    prod_nxt  = prod_r;
    neg_nxt   = neg_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          job_nxt.op        = in_data.op;
          job_nxt.connected = in_data.connected;
          job_nxt.buttons   = in_data.buttons;
          job_nxt.trig[0]   = in_data.trigger_left;
          job_nxt.trig[1]   = in_data.trigger_right;
          job_nxt.axis[0]   = in_data.left_x;
          job_nxt.axis[1]   = in_data.left_y;
          job_nxt.axis[2]   = in_data.right_x;
          job_nxt.axis[3]   = in_data.right_y;
          idx_nxt           = 3'd0;
          state_nxt         = F_CALC;
        end
      end
      F_CALC: begin
        // multiply axis idx while the previous product is saturated and stored
        if (idx_r != 3'd4) begin
          prod_nxt = 41'(excess * dead_zone_gain);
          neg_nxt  = raw[15];
        end
        if (idx_r != 3'd0) begin
          job_nxt.axis[2'(idx_r - 3'd1)] = signed_val;
        end
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd4) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      idx_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
    job_r  <= job_nxt;
    prod_r <= prod_nxt;
    neg_r  <= neg_nxt;
  end

endmodule

### design/gpev_queue.sv
// Two-entry queue of classified reports between front and back end.
module gpev_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gpev_pkg::job_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output gpev_pkg::job_t  pop_data
);
  import gpev_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign avail    = (cnt_r != 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/gpev_back.sv
// Back end: holds the cached report state and walks the event slots one per cycle unless the result side stalls.
module gpev_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            avail,
  input  gpev_pkg::job_t  pop_data,
  output logic            pop,
  input  logic [7:0]      trigger_threshold,
  input  logic [15:0]     button_map_mask,
  output logic            out_valid,
  input  logic            out_ready,
  output gpev_pkg::out_t  out_data
);
  import gpev_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_LOAD = 3'b010,
    B_RUN  = 3'b100
  } bstate_t;

  typedef struct packed {
    logic present;
    out_t ev;
  } slot_t;

  bstate_t               state_r, state_nxt;
  job_t                  job_r;
  logic [SLOT_COUNT-1:0] mask_r, mask_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic                  link_r;
  logic [15:0]           pbtn_r;
  logic [1:0][7:0]       ptrig_r;
  logic [3:0][15:0]      paxis_r;
  logic                  out_valid_r;
  out_t                  out_r;

  logic [SLOT_COUNT-1:0] load_mask;
  logic [SLOT_COUNT-1:0] slot_bit;
  logic [SLOT_COUNT-1:0] rest;
  slot_t                 cur;
  out_t                  cur_ev;
  logic                  go;
  logic                  emit;
  logic                  commit;
  logic                  clear;

  function automatic slot_t decode(input logic [SLOT_W-1:0] s, input job_t j,
                                   input logic lk, input logic [15:0] pb,
                                   input logic [1:0][7:0] pt,
                                   input logic [3:0][15:0] pa,
                                   input logic [7:0] thr, input logic [15:0] bm);
    slot_t      d;
    logic [3:0] bi;
    logic [1:0] td;
    logic [7:0] tc, tp;
    logic       now_p, was_p;
    axis_slot_t as;
    logic       pos;
    cross_t     cr;
    d = '0;
    bi = 4'(s - SLOT_BTN);
    td = 2'(s - SLOT_TRIG);
    tc = j.trig[td[1]];
    tp = pt[td[1]];
    now_p = tc > thr;
    was_p = tp > thr;
    as = axis_slot(4'(s - SLOT_AXIS));
    pos = (as.sub == 2'd1) == as.axis[0];
    cr = crossing($signed(pa[as.axis]), $signed(j.axis[as.axis]), pos);
    if (s < SLOT_BTN) begin
      d.present      = j.connected != lk;
      d.ev.event_kind = j.connected ? EV_CONNECT : EV_DISCONNECT;
      d.ev.forced    = s[0];
    end else if (s < SLOT_TRIG) begin
      d.present = j.connected && (pb[bi] ^ j.buttons[bi]) && bm[bi] &&
                  (32'(bi) < BUTTON_COUNT);
      d.ev.event_kind = EV_DIGITAL;
      d.ev.symbol_id  = {1'b0, bi};
      d.ev.pressed    = j.buttons[bi];
    end else if (s < SLOT_AXIS) begin
      if (!td[0]) begin
        d.present       = j.connected && (tc != tp);
        d.ev.event_kind = EV_ANALOG;
        d.ev.symbol_id  = SYM_TRIG + 5'(td[1]);
        d.ev.value      = {8'd0, tc};
      end else begin
        d.present       = j.connected && (tc != tp) && (now_p != was_p);
        d.ev.event_kind = EV_DIGITAL;
        d.ev.symbol_id  = SYM_TRIG_BTN + 5'(td[1]);
        d.ev.pressed    = now_p;
      end
    end else if (s < SLOT_W'(SLOT_COUNT)) begin
      if (as.sub == 2'd0) begin
        d.present       = j.connected;
        d.ev.event_kind = EV_ANALOG;
        d.ev.symbol_id  = SYM_AXIS + 5'(as.axis);
        d.ev.value      = j.axis[as.axis];
      end else begin
        d.present       = j.connected && cr.hit;
        d.ev.event_kind = EV_DIGITAL;
        d.ev.symbol_id  = dir_sym(as.axis, pos);
        d.ev.pressed    = cr.press;
      end
    end
    return d;
  endfunction

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      load_mask[i] = decode(SLOT_W'(i), job_r, link_r, pbtn_r, ptrig_r, paxis_r,
                            trigger_threshold, button_map_mask).present;
    end
  end

  assign cur       = decode(slot_r, job_r, link_r, pbtn_r, ptrig_r, paxis_r,
                            trigger_threshold, button_map_mask);
  assign slot_bit  = SLOT_COUNT'(1) << slot_r;
  assign rest      = mask_r & ~slot_bit;
  assign go        = !mask_r[slot_r] || !out_valid_r || out_ready;
  assign emit      = (state_r == B_RUN) && go && mask_r[slot_r];
  assign pop       = (state_r == B_IDLE) && avail;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    cur_ev      = cur.ev;
    cur_ev.last = (rest == '0);
  end

  always_comb begin
    state_nxt = state_r;
    mask_nxt  = mask_r;
    slot_nxt  = slot_r;
    commit    = 1'b0;
    clear     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (avail) begin
          state_nxt = B_LOAD;
        end
      end
      B_LOAD: begin
        slot_nxt = '0;
        mask_nxt = load_mask;
        if (job_r.op == OP_CLEAR) begin
          clear     = 1'b1;
          state_nxt = B_IDLE;
        end else if (load_mask == '0) begin
          commit    = 1'b1;
          state_nxt = B_IDLE;
        end else begin
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        if (go) begin
          mask_nxt = rest;
          slot_nxt = slot_r + 1'b1;
          if (rest == '0) begin
            commit    = 1'b1;
            state_nxt = B_IDLE;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      link_r      <= 1'b0;
      pbtn_r      <= '0;
      ptrig_r     <= '0;
      paxis_r     <= '0;
      mask_r      <= '0;
      slot_r      <= '0;
    end else begin
      state_r <= state_nxt;
      mask_r  <= mask_nxt;
      slot_r  <= slot_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (clear) begin
        ptrig_r <= '0;
        paxis_r <= '0;
      end
      if (commit) begin
        link_r <= job_r.connected;
        if (job_r.connected) begin
          pbtn_r  <= job_r.buttons;
          ptrig_r <= job_r.trig;
          paxis_r <= job_r.axis;
        end
      end
    end
    if (pop) begin
      job_r <= pop_data;
    end
    if (emit) begin
      out_r <= cur_ev;
    end
  end

endmodule

### design/gamepad_report_event_generator.sv
// Top level of the gamepad report event generator: config registers and wiring.
//
// Each accepted report goes through a front end that rescales the four stick
// axes with one shared 17x24 multiplier (the accept state, five multiply and
// store steps for the four axes, and a hand-off state that waits while the
// queue is full), then waits in a two-entry queue. The back end pops the queue
// when idle and loads the slot mask, then walks the event slots one per cycle,
// unless the result side stalls, up to the last event present (at most 34); a
// clear op or a disconnected report without a link change emits nothing and
// goes back to idle after the load. Front and back overlap, so the front end
// can take the next report while the back end emits. Events come out one beat
// per cycle at most, with last set on the final beat of a report.
module gamepad_report_event_generator (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  gpev_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output gpev_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [23:0]    cfg_wdata
);
  import gpev_pkg::*;

  logic [14:0] dead_zone_r;
  logic [23:0] gain_r;
  logic [7:0]  trig_thr_r;
  logic [15:0] btn_mask_r;

  logic        q_push, q_full, q_pop, q_avail;
  job_t        q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r <= 15'd7864;
      gain_r      <= 24'd86232;
      trig_thr_r  <= 8'd30;
      btn_mask_r  <= 16'd62463;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DEAD_ZONE: dead_zone_r <= cfg_wdata[14:0];
        CFG_GAIN:      gain_r      <= cfg_wdata;
        CFG_TRIG_THR:  trig_thr_r  <= cfg_wdata[7:0];
        CFG_BTN_MASK:  btn_mask_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  gpev_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .dead_zone      (dead_zone_r),
    .dead_zone_gain (gain_r),
    .push           (q_push),
    .push_data      (q_wdata),
    .full           (q_full)
  );

  gpev_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_rdata)
  );

  gpev_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .avail             (q_avail),
    .pop_data          (q_rdata),
    .pop               (q_pop),
    .trigger_threshold (trig_thr_r),
    .button_map_mask   (btn_mask_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data)
  );

endmodule

### verif/testbench.sv
// Self-checking testbench for the gamepad report event generator.
module testbench;
  import gpev_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t in_data;
  out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [23:0] cfg_wdata;
  bit hold_off;

  gamepad_report_event_generator dut (.*);

  // expected-event store plus a copy of the block's state
  class event_scoreboard;
    out_t pending[$];
    int errors;
    logic [14:0] dz;
    logic [23:0] gain;
    logic [7:0] thr;
    logic [15:0] mask;
    logic link;
    logic [15:0] prev_btn;
    logic [7:0] prev_trig[2];
    logic signed [15:0] prev_axis[4];

    function void init();
      dz = 15'd7864; gain = 24'd86232; thr = 8'd30; mask = 16'hF3FF;
      link = 0; prev_btn = 0;
      foreach (prev_trig[i]) prev_trig[i] = 0;
      foreach (prev_axis[i]) prev_axis[i] = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [23:0] v);
      case (idx)
        CFG_DEAD_ZONE: dz = v[14:0];
        CFG_GAIN:      gain = v;
        CFG_TRIG_THR:  thr = v[7:0];
        CFG_BTN_MASK:  mask = v[15:0];
        default: ;
      endcase
    endfunction

    function void push(ev_kind_t k, int sym, bit pr, logic signed [15:0] v, bit f);
      out_t e;
      e.event_kind = k; e.symbol_id = sym[4:0]; e.pressed = pr;
      e.value = v; e.forced = f; e.last = 0;
      pending.push_back(e);
    endfunction

    function logic signed [15:0] rescale(logic signed [15:0] raw);
      longint mag, ex, s;
      mag = raw < 0 ? -longint'(raw) : longint'(raw);
      ex = mag > dz ? mag - dz : 0;
      s = (ex * gain) >>> 16;
      if (s > 32767) s = 32767;
      return raw < 0 ? -s[15:0] : s[15:0];
    endfunction

    function void note_report(in_t r);
      int n0, cr;
      bit pos;
      logic [7:0] tg[2];
      logic signed [15:0] ax[4], raw[4];
      int psym[4] = '{27, 24, 31, 28};
      int nsym[4] = '{26, 25, 30, 29};
      bit pfirst[4] = '{0, 1, 0, 1};
      int t;
      n0 = pending.size();
      if (r.op == OP_CLEAR) begin
        foreach (prev_trig[i]) prev_trig[i] = 0;
        foreach (prev_axis[i]) prev_axis[i] = 0;
        return;
      end
      if (r.connected != link) begin
        link = r.connected;
        push(link ? EV_CONNECT : EV_DISCONNECT, 0, 0, 0, 0);
        push(link ? EV_CONNECT : EV_DISCONNECT, 0, 0, 0, 1);
      end
      if (r.connected) begin
        tg[0] = r.trigger_left; tg[1] = r.trigger_right;
        raw = '{r.left_x, r.left_y, r.right_x, r.right_y};
        foreach (ax[i]) ax[i] = rescale(raw[i]);
        for (int i = 0; i < 16; i++)
          if ((prev_btn[i] ^ r.buttons[i]) && mask[i]) push(EV_DIGITAL, i, r.buttons[i], 0, 0);
        for (int i = 0; i < 2; i++)
          if (tg[i] != prev_trig[i]) begin
            push(EV_ANALOG, 16 + i, 0, {8'd0, tg[i]}, 0);
            if ((tg[i] > thr) != (prev_trig[i] > thr))
              push(EV_DIGITAL, 22 + i, tg[i] > thr, 0, 0);
          end
        for (int i = 0; i < 4; i++) begin
          push(EV_ANALOG, 18 + i, 0, ax[i], 0);
          for (int k = 0; k < 2; k++) begin
            pos = (k == 0) == pfirst[i];
            t = pos ? 25000 : -25000;
            cr = -1;
            if (pos) begin
              if (prev_axis[i] >= t && ax[i] < t) cr = 0;
              else if (prev_axis[i] <= t && ax[i] > t) cr = 1;
            end else begin
              if (prev_axis[i] <= t && ax[i] > t) cr = 0;
              else if (prev_axis[i] >= t && ax[i] < t) cr = 1;
            end
            if (cr >= 0) push(EV_DIGITAL, pos ? psym[i] : nsym[i], cr[0], 0, 0);
          end
        end
        prev_btn = r.buttons;
        prev_trig = tg;
        prev_axis = ax;
      end
      if (pending.size() > n0) pending[pending.size() - 1].last = 1;
    endfunction

    function void check_event(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.event_kind != e.event_kind || got.symbol_id != e.symbol_id ||
          got.pressed != e.pressed || got.value !== e.value ||
          got.forced != e.forced || got.last != e.last) begin
        $display("%0t: event mismatch, expected %p, actual %p", $time, e, got);
        errors++;
      end
    endfunction
  endclass

  event_scoreboard sb;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("testbench: FAIL");
    $finish;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int w;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_event(out_data);
      if (hold_off) out_ready <= 0;
      else begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
        out_ready <= (w == 0);
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [23:0] v);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
  endtask

  // valid drops at the accept edge, and the next report starts after the requested gap
  task automatic send(in_t r, int gap);
    repeat (gap + 1) @(posedge clk);
    in_valid <= 1; in_data <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_report(r);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'(int'($urandom_range(0, 8000)) - 4000);
      3: return 16'($urandom_range(24000, 32767));
      4: return -16'($urandom_range(24000, 32767));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t rand_report();
    in_t r;
    r = in_t'($bits(in_t)'({$urandom, $urandom, $urandom, $urandom}));
    r.op = ($urandom_range(0, 15) == 0) ? OP_CLEAR : OP_REPORT;
    r.connected = ($urandom_range(0, 9) != 0);
    r.left_x = rand_axis(); r.left_y = rand_axis();
    r.right_x = rand_axis(); r.right_y = rand_axis();
    if ($urandom_range(0, 2) == 0) r.trigger_left = sb.prev_trig[0];
    return r;
  endfunction

  initial begin
    in_t r;
    sb = new();
    sb.init();
    rst_n = 0; in_valid = 0; in_data = '0; cfg_we = 0; cfg_index = CFG_DEAD_ZONE;
    cfg_wdata = 0; hold_off = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // directed: connect, extremes, crossings, clear, disconnect
    r = '0; r.connected = 1;
    send(r, 0);
    r.buttons = 16'hFFFF; r.trigger_left = 8'hFF; r.trigger_right = 8'd31;
    r.left_x = 16'sh7FFF; r.left_y = 16'sh8000; r.right_x = 16'sh8000; r.right_y = 16'sh7FFF;
    send(r, 1);
    r.buttons = 16'h0000; r.trigger_left = 8'd30; r.trigger_right = 8'd0;
    r.left_x = 16'sh8000; r.left_y = 16'sh7FFF; r.right_x = 0; r.right_y = 16'sd100;
    send(r, 0);
    r.op = OP_CLEAR; send(r, 2);
    r.op = OP_REPORT; send(r, 0);
    r.connected = 0; send(r, 0);
    send(r, 1);
    r.connected = 1; r.buttons = 16'h5A5A; send(r, 0);
    drain();

    // config sweep with random reports in each phase
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_DEAD_ZONE, 24'd0); write_reg(CFG_GAIN, 24'd65536);
          write_reg(CFG_TRIG_THR, 24'd0); write_reg(CFG_BTN_MASK, 24'hFFFF);
        end
        1: begin
          write_reg(CFG_DEAD_ZONE, 24'd29000); write_reg(CFG_GAIN, 24'hFFFFFF);
          write_reg(CFG_TRIG_THR, 24'd255); write_reg(CFG_BTN_MASK, 24'd0);
        end
        2: begin
          write_reg(CFG_DEAD_ZONE, 24'h7FFF); write_reg(CFG_GAIN, 24'd0);
          write_reg(CFG_TRIG_THR, 24'd128); write_reg(CFG_BTN_MASK, 24'h00A5);
        end
        3: begin
          write_reg(CFG_DEAD_ZONE, 24'($urandom_range(0, 29000)));
          write_reg(CFG_GAIN, 24'($urandom_range(65536, 300000)));
          write_reg(CFG_TRIG_THR, 24'($urandom_range(0, 255)));
          write_reg(CFG_BTN_MASK, 24'($urandom_range(0, 65535)));
        end
        default: begin
          write_reg(CFG_DEAD_ZONE, 24'd7864); write_reg(CFG_GAIN, 24'd86232);
          write_reg(CFG_TRIG_THR, 24'd30); write_reg(CFG_BTN_MASK, 24'hF3FF);
        end
      endcase
      if (ph == 3) begin
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int i = 0; i < 30; i++) begin
        send(rand_report(), (ph == 1) ? 0 : $urandom_range(0, 3));
        if (i == 15) drain();
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule
